// File: rtl/utf8cw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8cw_pkg
// Shared types and constants for the UTF-8 decoder with column width:
// lead byte patterns, width codes and the zero-width and wide code point spans.
// ----------------------------------------------------------------------------
package utf8cw_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int USED_W  = 3;
	localparam int WIDTH_W = 2;

	localparam int NUM_ZERO = 8;
	localparam int NUM_WIDE = 16;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [CP_W-1:0]    cp_t;
	typedef logic [USED_W-1:0]  used_t;
	typedef logic [WIDTH_W-1:0] width_t;

	typedef struct packed {
		cp_t lo;
		cp_t hi;
	} span_t;

	// lead byte classes
	localparam byte_t LEAD2_MASK = 8'hE0;
	localparam byte_t LEAD2_PAT  = 8'hC0;
	localparam byte_t LEAD3_MASK = 8'hF0;
	localparam byte_t LEAD3_PAT  = 8'hE0;
	localparam byte_t LEAD4_MASK = 8'hF8;
	localparam byte_t LEAD4_PAT  = 8'hF0;
	localparam byte_t CONT_MASK  = 8'hC0;
	localparam byte_t CONT_PAT   = 8'h80;

	// control ranges
	localparam cp_t C0_END   = 21'h00020;
	localparam cp_t C1_START = 21'h0007F;
	localparam cp_t C1_END   = 21'h0009F;

	localparam used_t USED_ONE   = 3'd1;
	localparam used_t USED_TWO   = 3'd2;
	localparam used_t USED_THREE = 3'd3;
	localparam used_t USED_FOUR  = 3'd4;

	localparam width_t WIDTH_ZERO   = 2'd0;
	localparam width_t WIDTH_NORMAL = 2'd1;
	localparam width_t WIDTH_WIDE   = 2'd2;

	localparam span_t ZERO_SPANS [NUM_ZERO] = '{
		'{lo: 21'h00300, hi: 21'h0036F},
		'{lo: 21'h00483, hi: 21'h00489},
		'{lo: 21'h01AB0, hi: 21'h01AFF},
		'{lo: 21'h0200B, hi: 21'h0200F},
		'{lo: 21'h0202A, hi: 21'h0202E},
		'{lo: 21'h02060, hi: 21'h02064},
		'{lo: 21'h0FE00, hi: 21'h0FE0F},
		'{lo: 21'h0FEFF, hi: 21'h0FEFF}
	};

	localparam span_t WIDE_SPANS [NUM_WIDE] = '{
		'{lo: 21'h01100, hi: 21'h0115F},
		'{lo: 21'h02E80, hi: 21'h0303E},
		'{lo: 21'h03041, hi: 21'h033FF},
		'{lo: 21'h03400, hi: 21'h04DBF},
		'{lo: 21'h04E00, hi: 21'h09FFF},
		'{lo: 21'h0A000, hi: 21'h0A4CF},
		'{lo: 21'h0AC00, hi: 21'h0D7A3},
		'{lo: 21'h0F900, hi: 21'h0FAFF},
		'{lo: 21'h0FE30, hi: 21'h0FE4F},
		'{lo: 21'h0FF00, hi: 21'h0FF60},
		'{lo: 21'h0FFE0, hi: 21'h0FFE6},
		'{lo: 21'h1F000, hi: 21'h1F02F},
		'{lo: 21'h1F300, hi: 21'h1F64F},
		'{lo: 21'h1F900, hi: 21'h1F9FF},
		'{lo: 21'h20000, hi: 21'h2FFFD},
		'{lo: 21'h30000, hi: 21'h3FFFD}
	};

endpackage
`default_nettype wire

// File: rtl/utf8_decode_column_width.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_decode_column_width
// Decodes one UTF-8 code point from a four byte window and classifies its
// terminal column width.
// ----------------------------------------------------------------------------
// Each beat on the item channel carries the bytes at the current string
// position and how many of them are valid; each beat on the result channel
// gives the code point, the bytes consumed (advance by this) and the column
// width (0, 1 or 2). A malformed or truncated sequence consumes one byte and
// returns the raw lead byte. One item is taken per cycle unless item_stall is
// high; each result passes the stages in order: stage one decodes the window,
// stage two compares the code point against every width span in parallel, stage
// three reduces the hits and holds the result. The pipeline holds up to three
// items and stops only when the result side stalls with every stage full.
module utf8_decode_column_width (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_stall,
	input  wire  utf8cw_pkg::byte_t lead_byte,
	input  wire  utf8cw_pkg::byte_t second_byte,
	input  wire  utf8cw_pkg::byte_t third_byte,
	input  wire  utf8cw_pkg::byte_t fourth_byte,
	input  wire  [2:0]              bytes_valid,
	output logic                    result_valid,
	input  wire                     result_stall,
	output utf8cw_pkg::cp_t         code_point,
	output utf8cw_pkg::used_t       bytes_used,
	output utf8cw_pkg::width_t      column_width
);
	import utf8cw_pkg::*;

	logic adv_s1, adv_s2, adv_s3;

	logic  valid_s1, valid_s2, valid_s3;
	cp_t   cp_s1, cp_s2, cp_s3;
	used_t used_s1, used_s2, used_s3;
	width_t width_s3;

	logic                ctrl_s2;
	logic [NUM_ZERO-1:0] zero_hit_s2;
	logic [NUM_WIDE-1:0] wide_hit_s2;

	// decode
	logic  avail2, avail3, avail4;
	logic  cont1, cont2, cont3;
	cp_t   cp_dec;
	used_t used_dec;

	// compare
	logic                ctrl_cmp;
	logic [NUM_ZERO-1:0] zero_hit_cmp;
	logic [NUM_WIDE-1:0] wide_hit_cmp;

	assign adv_s3     = !valid_s3 || !result_stall;
	assign adv_s2     = !valid_s2 || adv_s3;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_stall = !adv_s1;

	// zero counts as one, above four as four
	assign avail2 = (bytes_valid >= 3'd2);
	assign avail3 = (bytes_valid >= 3'd3);
	assign avail4 = (bytes_valid >= 3'd4);
	assign cont1  = ((second_byte & CONT_MASK) == CONT_PAT);
	assign cont2  = ((third_byte  & CONT_MASK) == CONT_PAT);
	assign cont3  = ((fourth_byte & CONT_MASK) == CONT_PAT);

	always_comb begin
		cp_dec   = {{(CP_W-BYTE_W){1'b0}}, lead_byte};
		used_dec = USED_ONE;
		if (lead_byte[7] == 1'b0) begin
			cp_dec   = {{(CP_W-BYTE_W){1'b0}}, lead_byte};
			used_dec = USED_ONE;
		end else if ((lead_byte & LEAD2_MASK) == LEAD2_PAT && avail2 && cont1) begin
			cp_dec   = {10'd0, lead_byte[4:0], second_byte[5:0]};
			used_dec = USED_TWO;
		end else if ((lead_byte & LEAD3_MASK) == LEAD3_PAT && avail3 && cont1
				&& cont2) begin
			cp_dec   = {5'd0, lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
			used_dec = USED_THREE;
		end else if ((lead_byte & LEAD4_MASK) == LEAD4_PAT && avail4 && cont1
				&& cont2 && cont3) begin
			cp_dec   = {lead_byte[2:0], second_byte[5:0], third_byte[5:0],
				fourth_byte[5:0]};
			used_dec = USED_FOUR;
		end
	end

	always_comb begin
		ctrl_cmp = (cp_s1 < C0_END) || (cp_s1 >= C1_START && cp_s1 <= C1_END);
		for (int i = 0; i < NUM_ZERO; i++) begin
			zero_hit_cmp[i] = (cp_s1 >= ZERO_SPANS[i].lo) && (cp_s1 <= ZERO_SPANS[i].hi);
		end
		for (int i = 0; i < NUM_WIDE; i++) begin
			wide_hit_cmp[i] = (cp_s1 >= WIDE_SPANS[i].lo) && (cp_s1 <= WIDE_SPANS[i].hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= item_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cp_s1   <= cp_dec;
			used_s1 <= used_dec;
		end
		if (adv_s2) begin
			cp_s2       <= cp_s1;
			used_s2     <= used_s1;
			ctrl_s2     <= ctrl_cmp;
			zero_hit_s2 <= zero_hit_cmp;
			wide_hit_s2 <= wide_hit_cmp;
		end
		if (adv_s3) begin
			cp_s3   <= cp_s2;
			used_s3 <= used_s2;
			if (ctrl_s2 || (|zero_hit_s2)) begin
				width_s3 <= WIDTH_ZERO;
			end else if (|wide_hit_s2) begin
				width_s3 <= WIDTH_WIDE;
			end else begin
				width_s3 <= WIDTH_NORMAL;
			end
		end
	end

	assign result_valid = valid_s3;
	assign code_point   = cp_s3;
	assign bytes_used   = used_s3;
	assign column_width = width_s3;

	a_single_byte_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bytes_used == USED_ONE |-> code_point[CP_W-1:BYTE_W] == '0)
		else $error("one byte beat with code point above a byte");

	a_two_byte_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bytes_used == USED_TWO |-> code_point[CP_W-1:11] == '0)
		else $error("two byte beat with code point above 11 bits");

	a_control_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && code_point < C0_END |-> column_width == WIDTH_ZERO)
		else $error("control code point with nonzero width");

	a_width_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> column_width == WIDTH_ZERO || column_width == WIDTH_NORMAL
			|| column_width == WIDTH_WIDE)
		else $error("bad column width code");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && result_stall |-> item_stall)
		else $error("item taken with full pipeline stalled");

endmodule
`default_nettype wire
